/* hdl/skctw_pkg.sv */
// ----------------------------------------------------------------------------
// skctw_pkg
// Shared types, constants and the key character table for the set-1 scancode
// key tracker and text writer.
// ----------------------------------------------------------------------------
package skctw_pkg;

	localparam int unsigned CODE_W  = 8;
	localparam int unsigned KEY_W   = 6;
	localparam int unsigned CELL_W  = 11;
	localparam int unsigned ATTR_W  = 8;
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = ATTR_W + CHAR_W;

	localparam int unsigned MAX_HELD_DEF     = 8;
	localparam int unsigned SCREEN_CELLS_DEF = 2000;

	localparam logic [CODE_W-1:0] LAST_MAKE    = 8'h39;
	localparam logic [CODE_W-1:0] BREAK_BASE   = 8'h80;
	localparam logic [CODE_W-1:0] BREAK_LAST   = 8'hB9;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'hF4;
	localparam logic [CELL_W-1:0] CURSOR_RESET = 11'd5;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

	localparam int unsigned NUM_KEYS = 58;

	localparam logic [CHAR_W-1:0] KEY_CHARS [0:NUM_KEYS-1] = '{
		" ", " ", "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "+", " ", " ",
		"q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", " ", " ", "a", "s",
		"d", "f", "g", "h", "j", "k", "l", ";", "'", " ", " ", " ", "z", "x", "c", "v",
		"b", "n", "m", ",", ".", "/", " ", " ", 8'h00, " "
	};

	typedef struct packed {
		logic             press;
		logic [KEY_W-1:0] key;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0]  cell_index;
		logic [VALUE_W-1:0] cell_value;
	} result_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH_RD,
		BK_SEARCH_CMP,
		BK_MOVE_RD,
		BK_MOVE_WR,
		BK_DECIDE
	} back_state_t;

	function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] key);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_SPACE;
		if (key <= KEY_W'(LAST_MAKE)) begin
			ch = KEY_CHARS[key];
		end
		return ch;
	endfunction

endpackage

/* hdl/skctw_queue.sv */
// ----------------------------------------------------------------------------
// skctw_queue
// Two-entry queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module skctw_queue #(
	parameter int unsigned WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] store_q [2];
	logic [1:0]       cnt_q;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

/* hdl/skctw_front.sv */
// ----------------------------------------------------------------------------
// skctw_front
// Input side: accept scancodes, classify make and break codes, drop the rest.
// ----------------------------------------------------------------------------
module skctw_front (
	input  logic                        push,
	output logic                        full,
	input  logic [skctw_pkg::CODE_W-1:0] scan_code,
	output logic                        cmd_push,
	input  logic                        cmd_full,
	output skctw_pkg::cmd_t             cmd
);
	import skctw_pkg::*;

	logic is_make;
	logic is_break;

	assign is_make  = (scan_code <= LAST_MAKE);
	assign is_break = (scan_code >= BREAK_BASE) && (scan_code <= BREAK_LAST);

	assign full      = cmd_full;
	assign cmd_push  = push && !cmd_full && (is_make || is_break);
	assign cmd.press = is_make;
	assign cmd.key   = scan_code[KEY_W-1:0];
endmodule

/* hdl/skctw_back.sv */
// ----------------------------------------------------------------------------
// skctw_back
// Execution side: search the held-key store one entry at a time, add or
// remove keys, and emit one text cell for each new press the store can hold.
// ----------------------------------------------------------------------------
module skctw_back #(
	parameter int unsigned MAX_HELD     = skctw_pkg::MAX_HELD_DEF,
	parameter int unsigned SCREEN_CELLS = skctw_pkg::SCREEN_CELLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_empty,
	output logic                         cmd_pop,
	input  skctw_pkg::cmd_t              cmd,
	input  logic [skctw_pkg::ATTR_W-1:0] text_attribute,
	input  logic                         res_full,
	output logic                         res_push,
	output skctw_pkg::result_t           res
);
	import skctw_pkg::*;

	localparam int unsigned IDX_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_HELD + 1);
	localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_HELD);
	localparam logic [CELL_W-1:0] CELL_TOP = CELL_W'(SCREEN_CELLS - 1);

	back_state_t state_q, state_d;

	logic [KEY_W-1:0]  held_mem [MAX_HELD];
	logic [KEY_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [KEY_W-1:0]  wr_data;

	logic              press_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  count_m1;
	logic [CELL_W-1:0] cursor_q, cursor_d;
	logic              load_cmd;

	assign count_m1 = count_q - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			count_q  <= '0;
			cursor_q <= CURSOR_RESET;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			idx_q    <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			press_q <= cmd.press;
			key_q   <= cmd.key;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= held_mem[rd_addr];
		if (wr_en) begin
			held_mem[wr_addr] <= wr_data;
		end
	end

	assign res.cell_index = cursor_q;
	assign res.cell_value = {text_attribute, key_char(key_q)};

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		idx_d    = idx_q;
		load_cmd = 1'b0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = rd_data_q;
		rd_addr  = idx_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop  = 1'b1;
					load_cmd = 1'b1;
					idx_d    = '0;
					state_d  = (count_q == '0) ? BK_DECIDE : BK_SEARCH_RD;
				end
			end
			BK_SEARCH_RD: begin
				state_d = BK_SEARCH_CMP;
			end
			BK_SEARCH_CMP: begin
				if (rd_data_q == key_q) begin
					state_d = press_q ? BK_IDLE : BK_MOVE_RD;
				end else if (CNT_W'(idx_q) == count_m1) begin
					state_d = BK_DECIDE;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = BK_SEARCH_RD;
				end
			end
			BK_MOVE_RD: begin
				rd_addr = count_m1[IDX_W-1:0];
				count_d = count_m1;
				state_d = BK_MOVE_WR;
			end
			BK_MOVE_WR: begin
				wr_en   = 1'b1;
				state_d = BK_IDLE;
			end
			BK_DECIDE: begin
				if (!press_q || count_q == CNT_MAX) begin
					state_d = BK_IDLE;
				end else if (!res_full) begin
					wr_en    = 1'b1;
					wr_addr  = count_q[IDX_W-1:0];
					wr_data  = key_q;
					count_d  = count_q + CNT_W'(1);
					res_push = 1'b1;
					cursor_d = (cursor_q == CELL_TOP) ? '0 : cursor_q + CELL_W'(1);
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end
endmodule

/* hdl/scancode_key_tracker_text_writer_top.sv */
// ----------------------------------------------------------------------------
// scancode_key_tracker_text_writer_top
// Set-1 scancode key tracker and text writer: tracks held keys and writes one
// attributed character cell for each new key press.
//
//   channel   handshake             payload
//   input     push / full           scan_code
//   result    pop / empty           cell_index, cell_value
//   config    cfg_valid / cfg_ready text_attribute
//
// The back end searches the held entries one at a time for each popped make
// or break code (one store read and compare per entry); a new press is added
// and written as a cell, a released key is removed by moving the last entry
// into its slot. Ignored codes are dropped at the input when accepted.
// Reset clears the key count, sets the cursor to 5 and the attribute to 0xF4.
// A full result queue holds the back end; a full command queue raises full.
// ----------------------------------------------------------------------------
module scancode_key_tracker_text_writer_top #(
	parameter int unsigned MAX_HELD     = skctw_pkg::MAX_HELD_DEF,
	parameter int unsigned SCREEN_CELLS = skctw_pkg::SCREEN_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [skctw_pkg::CODE_W-1:0]  scan_code,
	output logic                          empty,
	input  logic                          pop,
	output logic [skctw_pkg::CELL_W-1:0]  cell_index,
	output logic [skctw_pkg::VALUE_W-1:0] cell_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [skctw_pkg::ATTR_W-1:0]  text_attribute
);
	import skctw_pkg::*;

	logic [ATTR_W-1:0] attr_q;
	logic              cmd_push;
	logic              cmd_full;
	logic              cmd_empty;
	logic              cmd_pop;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic              res_push;
	logic              res_full;
	result_t           res_in;
	result_t           res_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= text_attribute;
		end
	end

	skctw_front u_front (
		.push      (push),
		.full      (full),
		.scan_code (scan_code),
		.cmd_push  (cmd_push),
		.cmd_full  (cmd_full),
		.cmd       (cmd_in)
	);

	skctw_queue #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (cmd_full),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_out)
	);

	skctw_back #(
		.MAX_HELD     (MAX_HELD),
		.SCREEN_CELLS (SCREEN_CELLS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (cmd_empty),
		.cmd_pop        (cmd_pop),
		.cmd            (cmd_out),
		.text_attribute (attr_q),
		.res_full       (res_full),
		.res_push       (res_push),
		.res            (res_in)
	);

	skctw_queue #(
		.WIDTH ($bits(result_t))
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res_in),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_out)
	);

	assign cell_index = res_out.cell_index;
	assign cell_value = res_out.cell_value;
endmodule

/* hdl/skctw_checker.sv */
// ----------------------------------------------------------------------------
// skctw_checker
// Port-level checks for the scancode key tracker and text writer.
// ----------------------------------------------------------------------------
module skctw_checker #(
	parameter int unsigned SCREEN_CELLS = skctw_pkg::SCREEN_CELLS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [skctw_pkg::CELL_W-1:0]  cell_index,
	input logic [skctw_pkg::VALUE_W-1:0] cell_value,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [skctw_pkg::ATTR_W-1:0]  text_attribute
);
	import skctw_pkg::*;

	localparam logic [CELL_W-1:0] CELL_TOP = CELL_W'(SCREEN_CELLS - 1);

	logic [ATTR_W-1:0] attr_q;
	logic              seen_q;
	logic [CELL_W-1:0] last_idx_q;
	logic [CELL_W-1:0] next_idx;

	assign next_idx = (last_idx_q == CELL_TOP) ? '0 : last_idx_q + CELL_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q     <= ATTR_RESET;
			seen_q     <= 1'b0;
			last_idx_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr_q <= text_attribute;
			end
			if (pop && !empty) begin
				seen_q     <= 1'b1;
				last_idx_q <= cell_index;
			end
		end
	end

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cell_index <= CELL_TOP))
		else $error("cell_index beyond screen");

	a_attribute: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (cell_value[VALUE_W-1:CHAR_W] == attr_q))
		else $error("cell attribute differs from configured value");

	a_cursor_step: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q && !empty) |-> (cell_index == next_idx))
		else $error("cursor did not advance by one cell");

	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(cell_index) && $stable(cell_value)))
		else $error("waiting result changed or vanished");
endmodule

bind scancode_key_tracker_text_writer_top skctw_checker #(
	.SCREEN_CELLS (SCREEN_CELLS)
) u_skctw_checker (.*);

/* verif/skctw_cell_checker.sv */
// ----------------------------------------------------------------------------
// skctw_cell_checker
// Watches the scancode, result and attribute channels of the key tracker and
// text writer. Keeps its own copy of the held-key set, the cursor and the
// attribute, works out the cell write that each accepted scancode causes and
// compares every popped result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module skctw_cell_checker #(
	parameter int unsigned MAX_HELD     = skctw_pkg::MAX_HELD_DEF,
	parameter int unsigned SCREEN_CELLS = skctw_pkg::SCREEN_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [skctw_pkg::CODE_W-1:0]  scan_code,
	input  logic                          pop,
	input  logic                          empty,
	input  logic [skctw_pkg::CELL_W-1:0]  cell_index,
	input  logic [skctw_pkg::VALUE_W-1:0] cell_value,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [skctw_pkg::ATTR_W-1:0]  text_attribute,
	output int                            cells_due,
	output int                            mismatch_cnt
);

	timeunit 1ns;
	timeprecision 1ps;

	import skctw_pkg::*;

	logic [KEY_W-1:0]  held_keys [MAX_HELD];
	int                held_cnt;
	logic [CELL_W-1:0] cursor;
	logic [ATTR_W-1:0] attr;
	result_t           cell_writes_due [$];
	int                errors;

	function automatic logic [CHAR_W-1:0] glyph_of(input logic [KEY_W-1:0] key);
		string row = "  1234567890-+  qwertyuiop[]  asdfghjkl;'   zxcvbnm,./  ";
		if (key == 6'h38) begin
			return 8'h00;
		end
		if (key < 6'h38) begin
			return row.getc(int'(key));
		end
		return " ";
	endfunction

	function automatic bit track_scan_code(input logic [CODE_W-1:0] code,
		output result_t write_out);
		logic [KEY_W-1:0] key;
		bit               is_press;
		write_out = '0;
		if (code <= LAST_MAKE) begin
			is_press = 1'b1;
			key      = code[KEY_W-1:0];
		end else if (code >= BREAK_BASE && code <= BREAK_LAST) begin
			is_press = 1'b0;
			key      = KEY_W'(code - BREAK_BASE);
		end else begin
			return 1'b0;
		end
		for (int i = 0; i < held_cnt; i++) begin
			if (held_keys[i] == key) begin
				if (!is_press) begin
					held_cnt--;
					held_keys[i] = held_keys[held_cnt];
				end
				return 1'b0;
			end
		end
		if (!is_press || held_cnt >= int'(MAX_HELD)) begin
			return 1'b0;
		end
		held_keys[held_cnt] = key;
		held_cnt++;
		write_out.cell_index = cursor;
		write_out.cell_value = {attr, glyph_of(key)};
		cursor = (cursor == CELL_W'(SCREEN_CELLS - 1)) ? '0 : cursor + 1'b1;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			held_cnt = 0;
			cursor   = CURSOR_RESET;
			attr     = ATTR_RESET;
			errors   = 0;
			cell_writes_due.delete();
			cells_due    <= 0;
			mismatch_cnt <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				attr = text_attribute;
			end
			if (push && !full) begin
				if (track_scan_code(scan_code, want)) begin
					cell_writes_due.push_back(want);
				end
			end
			if (pop && !empty) begin
				if (cell_writes_due.size() == 0) begin
					$error("unexpected transaction: cell_index %0d, cell_value %h",
						cell_index, cell_value);
					errors++;
				end else begin
					want = cell_writes_due.pop_front();
					if (cell_index !== want.cell_index) begin
						$error("cell_index: expected %0d, got %0d", want.cell_index, cell_index);
						errors++;
					end
					if (cell_value !== want.cell_value) begin
						$error("cell_value: expected %h, got %h", want.cell_value, cell_value);
						errors++;
					end
				end
			end
			cells_due    <= cell_writes_due.size();
			mismatch_cnt <= errors;
		end
	end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives scancodes and attribute writes into the key tracker and text writer
// and gives the verdict. A short directed run covers repeats, releases of
// keys not held, ignored codes, the blank keys and a full held set; random
// press and release traffic over small key pools, a run of press and release
// pairs and random back-pressure on both sides follow. Checking is done
// by the cell checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import skctw_pkg::*;

	localparam int LIMIT       = 1_000_000;
	localparam int SETTLE      = 4 * (2 * MAX_HELD_DEF + 4);
	localparam int LONG_HOLD   = 400;
	localparam int POOL_SIZE   = 12;
	localparam int SWEEP_PAIRS = 150;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [CODE_W-1:0]  scan_code;
	logic               empty;
	logic               pop;
	logic [CELL_W-1:0]  cell_index;
	logic [VALUE_W-1:0] cell_value;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [ATTR_W-1:0]  text_attribute;

	int               cells_due;
	int               mismatch_cnt;
	int               tx_idle_pct;
	int               rx_idle_pct;
	bit               quiet;
	int               hold_req_cnt;
	int               hold_served_cnt;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	scancode_key_tracker_text_writer_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.scan_code      (scan_code),
		.empty          (empty),
		.pop            (pop),
		.cell_index     (cell_index),
		.cell_value     (cell_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_attribute (text_attribute)
	);

	skctw_cell_checker i_cell_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.scan_code      (scan_code),
		.pop            (pop),
		.empty          (empty),
		.cell_index     (cell_index),
		.cell_value     (cell_value),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.text_attribute (text_attribute),
		.cells_due      (cells_due),
		.mismatch_cnt   (mismatch_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		for (int n = 0; n < LIMIT; n++) begin
			@(posedge clk);
		end
		$display("[scancode_key_tracker_text_writer_top] ERROR");
		$finish;
	end

	// drain results; hold pop low in random bursts or for one long stretch on request
	initial begin
		int gap;
		pop <= 1'b0;
		hold_served_cnt = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req_cnt != hold_served_cnt) begin
				hold_served_cnt++;
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
				pop <= 1'b0;
				gap = $urandom_range(1, 6);
				repeat (gap - 1) @(posedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send_code(input logic [CODE_W-1:0] code);
		int gap;
		if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		scan_code <= code;
		do @(posedge clk); while (full);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		cfg_valid      <= 1'b1;
		text_attribute <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (cells_due != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic refill_pool();
		foreach (key_pool[i]) begin
			key_pool[i] = KEY_W'($urandom_range(0, NUM_KEYS - 1));
		end
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int               r   = $urandom_range(0, 99);
		logic [KEY_W-1:0] key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 45) begin
			return {2'b00, key};
		end else if (r < 85) begin
			return BREAK_BASE | {2'b00, key};
		end else if (r < 93) begin
			return CODE_W'($urandom_range(0, BREAK_LAST));
		end
		return CODE_W'($urandom_range(0, 255));
	endfunction

	task automatic random_traffic(input int items);
		for (int n = 0; n < items; n++) begin
			if (n % 100 == 0) begin
				refill_pool();
			end
			send_code(pick_code());
		end
	endtask

	initial begin
		logic [CODE_W-1:0] directed [25] = '{
			8'h00, 8'h00, 8'h80, 8'h80, 8'h38, 8'h39, 8'h3A, 8'h7F, 8'hBA, 8'hFF,
			8'hB8, 8'hB9, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16, 8'h17,
			8'h18, 8'h93, 8'h18, 8'h90, 8'h97
		};
		logic [KEY_W-1:0] key;
		arst_n         <= 1'b0;
		push           <= 1'b0;
		scan_code      <= '0;
		cfg_valid      <= 1'b0;
		text_attribute <= '0;
		tx_idle_pct  = 25;
		rx_idle_pct  = 25;
		quiet        = 1'b0;
		hold_req_cnt = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_code(directed[i]);
		end
		wait_idle();

		write_attribute(8'h00);
		tx_idle_pct = 35;
		rx_idle_pct = 35;
		random_traffic(300);
		wait_idle();

		write_attribute(8'hFF);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		random_traffic(300);
		wait_idle();

		// press and release pairs; fill up during the hold
		write_attribute(ATTR_W'($urandom_range(1, 254)));
		tx_idle_pct = 15;
		rx_idle_pct = 15;
		hold_req_cnt++;
		for (int n = 0; n < SWEEP_PAIRS; n++) begin
			key = KEY_W'($urandom_range(0, NUM_KEYS - 1));
			send_code({2'b00, key});
			send_code(BREAK_BASE | {2'b00, key});
		end
		wait_idle();

		write_attribute(ATTR_W'($urandom_range(0, 255)));
		quiet = 1'b1;
		random_traffic(325);
		wait_idle();

		if (mismatch_cnt == 0 && cells_due == 0) begin
			$display("[scancode_key_tracker_text_writer_top] OK");
		end else begin
			$display("[scancode_key_tracker_text_writer_top] ERROR");
		end
		$finish;
	end

endmodule
